// ----- hdl/fpls_pkg.sv -----
// types, constants and command codes shared by the free-page list store
package fpls_pkg;

	// list geometry
	localparam int CAPACITY = 1022;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int DATA_W   = 32;
	localparam int CNT_W    = 10;
	localparam int IDX_W    = 10;
	localparam int CMD_W    = 3;

	// command codes
	localparam logic [CMD_W-1:0] CMD_READ_HDR  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE_HDR = 3'd1;
	localparam logic [CMD_W-1:0] CMD_GET       = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SET       = 3'd3;
	localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd5;

	// command word
	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [IDX_W-1:0]  index;
		logic [DATA_W-1:0] page_number;
		logic [DATA_W-1:0] next_link;
		logic [CNT_W-1:0]  new_count;
	} req_t;

	// result word
	typedef struct packed {
		logic              ok;
		logic [DATA_W-1:0] read_value;
		logic [CNT_W-1:0]  count_out;
	} rsp_t;

endpackage

// ----- hdl/fpls_page_ram.sv -----
// page number array: one write port, one registered read port
module fpls_page_ram import fpls_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [0:CAPACITY-1];
	logic [DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/free_page_list_store.sv -----
// free-page list store: header registers, page array and command sequencer
//
// Commands arrive on req and are taken at a clock edge where start is high and
// busy is low. Every command gives exactly one result word on rsp, shown for a
// single cycle with done high; the receiver has no way to hold it off.
// Header read, header write, set, append and any refused command: done rises
// in the cycle after the command is taken. A get waits for the registered
// array read, then registers the result word and done from it. A remove moves
// every later entry down one place through the single array port pair, one
// entry a cycle, then raises done. The array has one write and one read port.
// busy stays high until the result is out, so a new command can be taken in
// the cycle done is high.
// After reset the link word and count are zero and the array is swept to zero
// one entry a cycle; busy stays high until the sweep is done.
module free_page_list_store import fpls_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	localparam logic [CNT_W-1:0]  CAP_C  = CNT_W'(CAPACITY);
	localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(CAPACITY - 1);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_READ  = 4'b0100,
		ST_SHIFT = 4'b1000
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [DATA_W-1:0] link_q;
	logic [CNT_W-1:0]  count_q;
	logic              done_q;
	rsp_t              rsp_q;

	logic              accept;
	logic              idx_ok;
	logic              rm_ok;
	logic              rm_shift;
	logic              shift_more;
	logic [ADDR_W:0]   ptr_nxt2;
	logic [ADDR_W:0]   idx_inc;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [DATA_W-1:0] mem_rdata;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;

	// index checks and walk bounds
	assign idx_ok     = (req.index < IDX_W'(CAP_C));
	assign rm_ok      = (CNT_W'(req.index) < count_q);
	assign idx_inc    = {1'b0, ADDR_W'(req.index)} + (ADDR_W+1)'(1);
	assign rm_shift   = rm_ok && (idx_inc < (ADDR_W+1)'(count_q));
	assign ptr_nxt2   = {1'b0, ptr_q} + (ADDR_W+1)'(2);
	assign shift_more = (ptr_nxt2 <= (ADDR_W+1)'(count_q));

	// array port steering
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = ADDR_W'(req.index);
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				if (accept) begin
					case (req.cmd)
						CMD_SET: begin
							mem_we    = idx_ok;
							mem_waddr = ADDR_W'(req.index);
							mem_wdata = req.page_number;
						end
						CMD_APPEND: begin
							mem_we    = (count_q < CAP_C);
							mem_waddr = ADDR_W'(count_q);
							mem_wdata = req.page_number;
						end
						CMD_GET: begin
							mem_re = idx_ok;
						end
						CMD_REMOVE: begin
							mem_re    = rm_shift;
							mem_raddr = idx_inc[ADDR_W-1:0];
						end
						default: begin
						end
					endcase
				end
			end
			ST_SHIFT: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
				mem_re    = shift_more;
				mem_raddr = ptr_nxt2[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	fpls_page_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// result word
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			rsp_q <= '{ok: 1'b0, read_value: '0, count_out: count_q};
			case (req.cmd)
				CMD_READ_HDR: begin
					rsp_q <= '{ok: 1'b1, read_value: link_q, count_out: count_q};
				end
				CMD_WRITE_HDR: begin
					if (req.new_count <= CAP_C) begin
						rsp_q <= '{ok: 1'b1, read_value: '0, count_out: req.new_count};
					end
				end
				CMD_SET: begin
					rsp_q.ok <= idx_ok;
				end
				CMD_APPEND: begin
					if (count_q < CAP_C) begin
						rsp_q <= '{ok: 1'b1, read_value: '0, count_out: count_q + CNT_W'(1)};
					end
				end
				CMD_REMOVE: begin
					if (rm_ok) begin
						rsp_q <= '{ok: 1'b1, read_value: '0, count_out: count_q - CNT_W'(1)};
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == ST_READ) begin
			rsp_q <= '{ok: 1'b1, read_value: mem_rdata, count_out: count_q};
		end
	end

	// sequencer and header registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ptr_q   <= '0;
			link_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					ptr_q <= ptr_q + ADDR_W'(1);
					if (ptr_q == LAST_A) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						done_q <= 1'b1;
						case (req.cmd)
							CMD_WRITE_HDR: begin
								if (req.new_count <= CAP_C) begin
									link_q  <= req.next_link;
									count_q <= req.new_count;
								end
							end
							CMD_GET: begin
								if (idx_ok) begin
									done_q  <= 1'b0;
									state_q <= ST_READ;
								end
							end
							CMD_APPEND: begin
								if (count_q < CAP_C) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_REMOVE: begin
								if (rm_ok) begin
									count_q <= count_q - CNT_W'(1);
								end
								if (rm_shift) begin
									done_q  <= 1'b0;
									ptr_q   <= ADDR_W'(req.index);
									state_q <= ST_SHIFT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SHIFT: begin
					if (shift_more) begin
						ptr_q <= ptr_q + ADDR_W'(1);
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// sweep never reports a result
	a_no_done_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !done_q)
		else $error("result strobe during clearing sweep");

	// count never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	// shift destination stays inside the shortened list
	a_shift_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (CNT_W'(ptr_q) < count_q))
		else $error("shift pointer beyond entry count");

	// commands other than get and remove answer on the next cycle
	a_quick_done: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.cmd != CMD_GET && req.cmd != CMD_REMOVE) |=> done_q)
		else $error("missing result for single-cycle command");

endmodule

// ----- tb/free_page_list_store_test.sv -----
// testbench for the free-page list store: directed table, then random commands
`timescale 1ns / 100ps

module free_page_list_store_test;
	import fpls_pkg::*;

	// command codes the block leaves unused
	localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;
	localparam int RANDOM_WORDS = 530;

	// one row of the directed table
	typedef struct {
		req_t word;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	// shadow copy of the list
	logic [DATA_W-1:0] page_store [CAPACITY];
	logic [DATA_W-1:0] list_link;
	int                list_count;

	rsp_t     pending [$];
	dir_row_t dir_rows [$];
	bit       typed_given;
	rsp_t     typed_word;
	int       mismatch_count;
	int       result_index;

	free_page_list_store dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard limit on run time
	initial begin
		#5000000;
		$display("FAIL free_page_list_store");
		$finish;
	end

	// apply one command to the shadow list and return the word it should give
	function automatic rsp_t apply_page_cmd(input req_t w);
		rsp_t r;
		int   i;
		r = '0;
		case (w.cmd)
			CMD_READ_HDR: begin
				r.ok = 1'b1;
				r.read_value = list_link;
			end
			CMD_WRITE_HDR: begin
				if (w.new_count <= CAPACITY) begin
					list_link = w.next_link;
					list_count = int'(w.new_count);
					r.ok = 1'b1;
				end
			end
			CMD_GET: begin
				if (w.index < CAPACITY) begin
					r.read_value = page_store[w.index];
					r.ok = 1'b1;
				end
			end
			CMD_SET: begin
				if (w.index < CAPACITY) begin
					page_store[w.index] = w.page_number;
					r.ok = 1'b1;
				end
			end
			CMD_APPEND: begin
				if (list_count < CAPACITY) begin
					page_store[list_count] = w.page_number;
					list_count++;
					r.ok = 1'b1;
				end
			end
			CMD_REMOVE: begin
				// shift the tail down, old last slot stays as it was
				if (w.index < list_count) begin
					for (i = int'(w.index); i + 1 < list_count; i++)
						page_store[i] = page_store[i + 1];
					list_count--;
					r.ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.count_out = CNT_W'(list_count);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		$display("mismatch word %0d %s: got %h want %h at %0t",
			result_index, what, got, want, $time);
		mismatch_count++;
	endtask

	// check result words and record accepted commands
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (pending.size() == 0) begin
					report_mismatch("with nothing pending", rsp.read_value, '0);
				end else begin
					want = pending.pop_front();
					if (rsp.ok !== want.ok)
						report_mismatch("ok", DATA_W'(rsp.ok), DATA_W'(want.ok));
					if (rsp.read_value !== want.read_value)
						report_mismatch("read_value", rsp.read_value, want.read_value);
					if (rsp.count_out !== want.count_out)
						report_mismatch("count_out", DATA_W'(rsp.count_out),
							DATA_W'(want.count_out));
				end
				result_index++;
			end
			if (start === 1'b1 && busy === 1'b0) begin
				want = apply_page_cmd(req);
				if (typed_given)
					want = typed_word;
				pending.push_back(want);
			end
		end
	end

	task automatic add_row(input logic [CMD_W-1:0] cmd, input int idx,
			input logic [DATA_W-1:0] page, input logic [DATA_W-1:0] link,
			input int cnt, input bit typed, input bit ok,
			input logic [DATA_W-1:0] rv, input int cnt_out);
		dir_row_t row;
		row.word.cmd = cmd;
		row.word.index = IDX_W'(idx);
		row.word.page_number = page;
		row.word.next_link = link;
		row.word.new_count = CNT_W'(cnt);
		row.typed = typed;
		row.want.ok = ok;
		row.want.read_value = rv;
		row.want.count_out = CNT_W'(cnt_out);
		dir_rows.push_back(row);
	endtask

	// drive one word at the current falling edge and hold it until taken
	task automatic issue(input req_t w, input bit typed, input rsp_t want);
		start <= 1'b1;
		req <= w;
		typed_given = typed;
		typed_word = want;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// idle the sender by holding start low between bursts
	task automatic idle_gap(input int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// random command, mostly aimed at the live part of the list
	function automatic req_t make_random_cmd();
		req_t w;
		int   pick;
		int   sub;
		int   top;
		w.cmd = CMD_READ_HDR;
		w.index = IDX_W'($urandom_range(0, 1023));
		w.page_number = $urandom;
		w.next_link = $urandom;
		w.new_count = CNT_W'($urandom_range(0, 1023));
		pick = $urandom_range(0, 99);
		sub = $urandom_range(0, 99);
		top = (list_count + 3 > 1023) ? 1023 : list_count + 3;
		if (pick < 6) begin
			w.cmd = CMD_READ_HDR;
		end else if (pick < 14) begin
			w.cmd = CMD_WRITE_HDR;
			if (sub < 70)
				w.new_count = CNT_W'($urandom_range(0, 24));
			else if (sub < 85)
				w.new_count = CNT_W'($urandom_range(CAPACITY - 6, CAPACITY));
			else if (sub < 95)
				w.new_count = CNT_W'(CAPACITY + 1);
		end else if (pick < 48) begin
			w.cmd = (pick < 31) ? CMD_GET : CMD_SET;
			if (sub < 70)
				w.index = IDX_W'($urandom_range(0, top));
		end else if (pick < 73) begin
			w.cmd = CMD_APPEND;
		end else if (pick < 96) begin
			w.cmd = CMD_REMOVE;
			// long shifts only now and then
			if (list_count > 0 && sub < 80) begin
				if (list_count <= 64 || sub < 4)
					w.index = IDX_W'($urandom_range(0, list_count - 1));
				else
					w.index = IDX_W'($urandom_range(list_count - 8, list_count - 1));
			end
		end else begin
			w.cmd = (sub < 50) ? CMD_RSVD6 : CMD_RSVD7;
		end
		return w;
	endfunction

	// stimulus
	initial begin
		req_t w;
		rsp_t none;
		int   burst_left;
		int   n;

		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		typed_given = 1'b0;
		typed_word = '0;
		none = '0;
		mismatch_count = 0;
		result_index = 0;
		list_link = '0;
		list_count = 0;
		foreach (page_store[i])
			page_store[i] = '0;

		// directed table
		add_row(CMD_READ_HDR, 0, 0, 0, 0, 1, 1, 0, 0);
		add_row(CMD_GET, 0, 0, 0, 0, 1, 1, 0, 0);
		add_row(CMD_GET, CAPACITY - 1, 0, 0, 0, 1, 1, 0, 0);
		add_row(CMD_GET, CAPACITY, 0, 0, 0, 1, 0, 0, 0);
		add_row(CMD_SET, 1023, '1, 0, 0, 1, 0, 0, 0);
		add_row(CMD_SET, CAPACITY - 1, '1, 0, 0, 1, 1, 0, 0);
		add_row(CMD_GET, CAPACITY - 1, 0, 0, 0, 1, 1, '1, 0);
		add_row(CMD_REMOVE, 0, 0, 0, 0, 1, 0, 0, 0);
		add_row(CMD_APPEND, 0, 32'ha5a5_0001, 0, 0, 1, 1, 0, 1);
		// count above capacity refused, then the largest legal count
		add_row(CMD_WRITE_HDR, 0, 0, '1, 1023, 1, 0, 0, 1);
		add_row(CMD_WRITE_HDR, 0, 0, '1, CAPACITY, 1, 1, 0, CAPACITY);
		add_row(CMD_READ_HDR, 0, 0, 0, 0, 1, 1, '1, CAPACITY);
		add_row(CMD_APPEND, 0, '1, 0, 0, 1, 0, 0, CAPACITY);
		add_row(CMD_REMOVE, 1023, 0, 0, 0, 1, 0, 0, CAPACITY);
		// remove of the last entry leaves its slot alone
		add_row(CMD_REMOVE, CAPACITY - 1, 0, 0, 0, 1, 1, 0, CAPACITY - 1);
		add_row(CMD_GET, CAPACITY - 1, 0, 0, 0, 1, 1, '1, CAPACITY - 1);
		// full-length shift
		add_row(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_GET, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_RSVD6, 1023, '1, '1, 1023, 1, 0, 0, CAPACITY - 2);
		add_row(CMD_RSVD7, 1023, '1, '1, 1023, 1, 0, 0, CAPACITY - 2);
		add_row(CMD_WRITE_HDR, 0, 0, 0, 3, 1, 1, 0, 3);
		add_row(CMD_SET, 2, 32'h1234_5678, 0, 0, 0, 0, 0, 0);
		add_row(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_GET, 1, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_GET, 2, 0, 0, 0, 0, 0, 0, 0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words back to back
		foreach (dir_rows[k]) begin
			@(negedge clk);
			issue(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].want);
		end

		// random words in bursts
		burst_left = $urandom_range(1, 40);
		for (n = 0; n < RANDOM_WORDS; n++) begin
			if (burst_left == 0) begin
				idle_gap($urandom_range(1, 6));
				burst_left = $urandom_range(1, 40);
			end
			@(negedge clk);
			w = make_random_cmd();
			issue(w, 1'b0, none);
			burst_left--;
		end
		@(negedge clk);
		start <= 1'b0;

		// drain
		while (pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatch_count == 0)
			$display("PASS free_page_list_store");
		else
			$display("FAIL free_page_list_store");
		$finish;
	end

endmodule
